// File: design/brq_pkg.sv
package brq_pkg;

  localparam int ValueW = 31;
  localparam int SecW   = 32;
  localparam int UsecW  = 20;
  localparam int PosW   = 4;
  localparam int CountW = 5;
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic [2:0] ACT_ENQ  = 3'd0;
  localparam logic [2:0] ACT_DEQ  = 3'd1;
  localparam logic [2:0] ACT_REM  = 3'd2;
  localparam logic [2:0] ACT_FIND = 3'd3;
  localparam logic [2:0] ACT_PEEK = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SecW-1:0]   sec;
    logic [UsecW-1:0]  usec;
  } brq_entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } brq_cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } brq_state_t;

endpackage

// File: design/bounded_request_queue_top.sv
// Bounded request queue with indexed removal.
// Input channel (in_valid/in_stall) carries one request beat: an action code with a value,
// an arrival time and a position. Output channel (out_valid/out_stall) returns one result
// beat per request: success flag, removed value, found position, head time, count and
// the full and empty flags, all as they stand after the action.
// Entries live in a row of cells kept packed from the head; a removal shifts every
// cell behind the removed one forward together, and a search compares all cells
// at once and picks the first hit.
// A request is registered when accepted; its result is registered in the output register
// in the execute step of the request sequencer. The sequencer takes no new request until
// the last one has executed; in_stall is high during the execute step.
// If a finished result is still held under out_stall, the next accepted request waits
// in its execute step until the output register frees.
// Reset empties the queue, clears out_valid and sets capacity to 16. Capacity is written
// over the APB port at address 0; 0 acts as 1 and values above DEPTH act as DEPTH.
module bounded_request_queue_top
  import brq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        action,
  input  logic [ValueW-1:0] item_value,
  input  logic [SecW-1:0]   arrival_sec,
  input  logic [UsecW-1:0]  arrival_usec,
  input  logic [PosW-1:0]   position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [ValueW-1:0] out_value,
  output logic [PosW-1:0]   found_position,
  output logic [SecW-1:0]   head_sec,
  output logic [UsecW-1:0]  head_usec,
  output logic [CountW-1:0] count,
  output logic              is_full,
  output logic              is_empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CapW) ? CW : CapW;
  // Fill never exceeds the largest capacity, so only that many cells can hit a search.
  localparam int SW = (DEPTH < 31) ? DEPTH : 31;

  brq_state_t state, state_next;

  logic [CapW-1:0] capacity;
  logic [EW-1:0]   eff_cap;
  logic [CW-1:0]   fill, fill_next;
  logic [EW-1:0]   fill_e, fill_next_e;

  logic [2:0]        req_action;
  logic [PosW-1:0]   req_pos;
  brq_entry_t        req_item;

  brq_entry_t    cell_data [DEPTH];
  brq_entry_t    cell_nbr  [DEPTH];
  brq_cell_ctl_t cell_ctl  [DEPTH];
  logic [DEPTH-1:0] cell_match;

  logic            exec_go;
  logic            enq_ok, rem_ok, find_ok;
  logic [PosW-1:0] rem_pos;
  logic [PosW-1:0] find_pos;
  logic            res_ok;
  logic [ValueW-1:0] res_value;
  brq_entry_t      head_next;
  logic [ValueW-1:0] removed_value;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CapW){1'b0}}, capacity} : 32'd0;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(capacity) > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = EW'(capacity);
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    exec_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || !out_stall) begin
          exec_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_action     <= action;
      req_pos        <= position;
      req_item.value <= item_value;
      req_item.sec   <= arrival_sec;
      req_item.usec  <= arrival_usec;
    end
  end

  // Decode of the request against the current fill
  assign fill_e  = EW'(fill);
  assign rem_pos = (req_action == ACT_DEQ) ? '0 : req_pos;

  always_comb begin
    enq_ok = 1'b0;
    rem_ok = 1'b0;
    case (req_action)
      ACT_ENQ: enq_ok = (fill_e < eff_cap);
      ACT_DEQ: rem_ok = (fill != '0);
      ACT_REM: rem_ok = (EW'(req_pos) < fill_e);
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].load  = exec_go && enq_ok && (fill_e == EW'(i));
      cell_ctl[i].shift = exec_go && rem_ok && (EW'(i) >= EW'(rem_pos));
      cell_nbr[i]       = (i + 1 < DEPTH) ? cell_data[(i + 1) % DEPTH] : '0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    brq_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[g]),
      .item  (req_item),
      .nbr   (cell_nbr[g]),
      .key   (req_item.value),
      .data  (cell_data[g]),
      .match (cell_match[g])
    );
  end

  // First hit among the held entries; scanning down leaves the lowest position.
  always_comb begin
    find_ok  = 1'b0;
    find_pos = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (cell_match[i] && (EW'(i) < fill_e)) begin
        find_ok  = 1'b1;
        find_pos = PosW'(i);
      end
    end
  end

  assign removed_value = cell_data[rem_pos].value;

  always_comb begin
    fill_next = fill;
    if (enq_ok) begin
      fill_next = fill + CW'(1);
    end else if (rem_ok) begin
      fill_next = fill - CW'(1);
    end
  end

  assign fill_next_e = EW'(fill_next);

  always_comb begin
    if (fill_next == '0) begin
      head_next = '0;
    end else if (enq_ok && (fill == '0)) begin
      head_next = req_item;
    end else if (rem_ok && (rem_pos == '0)) begin
      head_next = cell_data[1];
    end else begin
      head_next = cell_data[0];
    end
  end

  always_comb begin
    res_ok    = 1'b0;
    res_value = '0;
    case (req_action)
      ACT_ENQ: res_ok = enq_ok;
      ACT_DEQ, ACT_REM: begin
        res_ok    = rem_ok;
        res_value = rem_ok ? removed_value : '0;
      end
      ACT_FIND: res_ok = find_ok;
      ACT_PEEK: res_ok = (fill != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (exec_go) begin
      fill <= fill_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      ok             <= res_ok;
      out_value      <= res_value;
      found_position <= (req_action == ACT_FIND && find_ok) ? find_pos : '0;
      head_sec       <= head_next.sec;
      head_usec      <= head_next.usec;
      count          <= fill_next_e[CountW-1:0];
      is_full        <= (fill_next_e >= eff_cap);
      is_empty       <= (fill_next == '0);
    end
  end

endmodule

// File: design/brq_cell.sv
module brq_cell
  import brq_pkg::*;
(
  input  logic          clk,
  input  brq_cell_ctl_t ctl,
  input  brq_entry_t    item,
  input  brq_entry_t    nbr,
  input  logic [ValueW-1:0] key,
  output brq_entry_t    data,
  output logic          match
);

  brq_entry_t entry;

  // A load writes the new tail; a shift pulls the neighbor one slot toward the head.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= item;
    end else if (ctl.shift) begin
      entry <= nbr;
    end
  end

  assign data  = entry;
  assign match = (entry.value == key);

endmodule

// File: design/brq_checker.sv
module brq_checker
  import brq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              ok,
  input logic [ValueW-1:0] out_value,
  input logic [PosW-1:0]   found_position,
  input logic [SecW-1:0]   head_sec,
  input logic [UsecW-1:0]  head_usec,
  input logic [CountW-1:0] count,
  input logic              is_empty
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(count) && $stable(ok)
      && $stable(out_value))
    else $error("result beat changed while stalled");

  // An accepted request occupies the sequencer for its execute step.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted during execute cycle");

  // The empty flag agrees with the count, and an empty queue shows no head time.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0))
      && (!is_empty || (head_sec == '0 && head_usec == '0)))
    else $error("empty flag, count and head time disagree");

  // A failed action reports no removed value and no found position.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> out_value == '0 && found_position == '0)
    else $error("failed action reported data");

endmodule

bind bounded_request_queue_top brq_checker u_brq_checker (.*);
